>>> hdl/rmth_pkg.sv
// Shared types and constants for the running median block.
// No dependencies; compile first.
`default_nettype none
package rmth_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned SAMPLE_W     = 32;
  localparam int unsigned MED_W        = 33;
  localparam int unsigned HELD_W       = 11;

  // Per-cycle datapath command from the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FLAG_OVF,
    OP_PUSH_SAMPLE,
    OP_UP_READ,
    OP_UP_MOVE,
    OP_WRITE_VAL,
    OP_POP_START,
    OP_POP_LAST,
    OP_DN_READ_L,
    OP_DN_READ_R,
    OP_DN_MOVE,
    OP_REPUSH,
    OP_RESULT
  } op_t;

  // Datapath flags seen by the controller.
  typedef struct packed {
    logic full;
    logic pos_zero;
    logic up_above;
    logic l_in;
    logic dn_move;
    logic n_zero;
    logic unbalanced;
  } status_t;

endpackage
`default_nettype wire

>>> hdl/rmth_sample_if.sv
// Request channel carrying one input sample.
// Depends on rmth_pkg.
`default_nettype none
interface rmth_sample_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [rmth_pkg::SAMPLE_W-1:0]    sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

>>> hdl/rmth_result_if.sv
// Request channel carrying one result.
// Depends on rmth_pkg.
`default_nettype none
interface rmth_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rmth_pkg::MED_W-1:0]    median_doubled;
  logic        [rmth_pkg::HELD_W-1:0]   held_count;
  logic                                 overflow;
  modport source (output valid, output median_doubled, output held_count, output overflow,
                  input ready);
  modport sink   (input valid, input median_doubled, input held_count, input overflow,
                  output ready);
endinterface
`default_nettype wire

>>> hdl/running_median_two_heaps_top.sv
// Top level of the two-heap running median: controller plus datapath.
// Depends on rmth_pkg, rmth_sample_if, rmth_result_if, rmth_controller, rmth_datapath.
//
//   channel     | dir | payload                                   | per request
//   ------------+-----+-------------------------------------------+-------------
//   sample_in   | in  | sample (s32)                              | one sample
//   result_out  | out | median_doubled (s33), held_count (u11),   | one result
//               |     | overflow (1)                              |
//
// Sift walks: the insert sift-up, then on a rebalance the pop sift-down and
// the re-insert sift-up, each one heap level at a time; the pace is set by the
// single read port of each heap memory. A full store skips the heap walks and
// goes straight to the result.
// Reset: synchronous, active high; clears counts and handshake state only,
// the heap memories need no clearing.
// Stalls: the result sits in an output register; the next sample is taken
// while it waits, and only the next result waits for it to leave.
`default_nettype none
module running_median_two_heaps_top #(
  parameter int unsigned CAPACITY = rmth_pkg::CAPACITY_DEF
) (
  input wire logic      clk,
  input wire logic      rst,
  rmth_sample_if.sink   sample_in,
  rmth_result_if.source result_out
);
  import rmth_pkg::*;

  status_t status;   // datapath flags
  op_t     op;       // command this cycle

  // Sequencer: one request at a time; walks insert, optional rebalance
  // (pop then re-insert into the other heap) and loads the result.
  rmth_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_in.valid),
    .in_ready  (sample_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .status    (status),
    .op        (op)
  );

  // Heap storage (max-heap below, min-heap above), counts, cached tops
  // and the result register.
  rmth_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .sample_d       (sample_in.sample),
    .status         (status),
    .median_doubled (result_out.median_doubled),
    .held_count     (result_out.held_count),
    .overflow       (result_out.overflow)
  );

endmodule
`default_nettype wire

>>> hdl/rmth_datapath.sv
// Heap memories, counts, cached tops, sift registers and result register.
// Depends on rmth_pkg.
`default_nettype none
module rmth_datapath #(
  parameter int unsigned CAPACITY = rmth_pkg::CAPACITY_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire rmth_pkg::op_t                        op,
  input  wire logic signed [rmth_pkg::SAMPLE_W-1:0] sample_d,
  output rmth_pkg::status_t                         status,
  output logic signed [rmth_pkg::MED_W-1:0]         median_doubled,
  output logic        [rmth_pkg::HELD_W-1:0]        held_count,
  output logic                                      overflow
);
  import rmth_pkg::*;

  localparam int unsigned HEAP_DEPTH = CAPACITY / 2 + 2;
  localparam int unsigned AW   = $clog2(HEAP_DEPTH);
  localparam int unsigned CNTW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned SUMW = CNTW + 1;
  localparam int unsigned IW   = AW + 2;

  logic signed [SAMPLE_W-1:0] lower_mem [HEAP_DEPTH];
  logic signed [SAMPLE_W-1:0] upper_mem [HEAP_DEPTH];
  logic signed [SAMPLE_W-1:0] lower_rd, upper_rd, rdata;

  logic [CNTW-1:0] lower_count, upper_count, n;
  logic signed [SAMPLE_W-1:0] lower_top, upper_top, val, popped, cl, sample_r;
  logic [AW-1:0] pos;
  logic          sel;      // 0: lower (max) heap, 1: upper (min) heap
  logic          ovf;

  logic [CNTW-1:0] cnt_sel, cnt_oth, cnt_big;
  logic [SUMW-1:0] held;
  logic            to_upper, lower_big, bl, br;
  logic [AW-1:0]   par;
  logic [IW-1:0]   lidx, ridx;
  logic signed [SAMPLE_W-1:0] bestv;

  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  logic signed [SAMPLE_W-1:0] wdata;
  logic signed [MED_W-1:0]    lo_ext, up_ext;

  always_comb begin
    cnt_sel   = sel ? upper_count : lower_count;
    cnt_oth   = sel ? lower_count : upper_count;
    held      = SUMW'(lower_count) + SUMW'(upper_count);
    to_upper  = !((lower_count == '0) || (sample_r <= lower_top));
    lower_big = lower_count > upper_count;
    cnt_big   = lower_big ? lower_count : upper_count;
    rdata     = sel ? upper_rd : lower_rd;
    par       = AW'((pos - AW'(1)) >> 1);
    lidx      = IW'({pos, 1'b1});
    ridx      = lidx + IW'(1);
    bl        = sel ? (cl < val) : (cl > val);
    bestv     = bl ? cl : val;
    br        = (ridx < IW'(n)) && (sel ? (rdata < bestv) : (rdata > bestv));

    status.full       = held >= SUMW'(CAPACITY);
    status.pos_zero   = pos == '0;
    status.up_above   = sel ? (val < rdata) : (val > rdata);
    status.l_in       = lidx < IW'(n);
    status.dn_move    = bl || br;
    status.n_zero     = cnt_sel == '0;
    status.unbalanced = (SUMW'(lower_count) > SUMW'(upper_count) + SUMW'(1)) ||
                        (SUMW'(upper_count) > SUMW'(lower_count) + SUMW'(1));
  end

  // Memory port control.
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = pos;
    raddr = par;
    wdata = val;
    unique case (op)
      OP_WRITE_VAL: we = 1'b1;
      OP_UP_MOVE: begin
        we    = 1'b1;
        wdata = rdata;
      end
      OP_DN_MOVE: begin
        we    = 1'b1;
        wdata = br ? rdata : cl;
      end
      OP_UP_READ: re = 1'b1;
      OP_POP_START: begin
        re    = 1'b1;
        raddr = AW'(cnt_big - CNTW'(1));
      end
      OP_DN_READ_L: begin
        re    = 1'b1;
        raddr = lidx[AW-1:0];
      end
      OP_DN_READ_R: begin
        re    = 1'b1;
        raddr = ridx[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we && !sel) lower_mem[waddr] <= wdata;
    if (we && sel)  upper_mem[waddr] <= wdata;
    if (re) begin
      lower_rd <= lower_mem[raddr];
      upper_rd <= upper_mem[raddr];
    end
  end

  assign lo_ext = (lower_count != '0) ? MED_W'(lower_top) : '0;
  assign up_ext = (upper_count != '0) ? MED_W'(upper_top) : '0;

  always_ff @(posedge clk) begin
    if (we && waddr == '0) begin
      if (sel) upper_top <= wdata;
      else     lower_top <= wdata;
    end
    unique case (op)
      OP_LOAD: begin
        sample_r <= sample_d;
        ovf      <= 1'b0;
      end
      OP_FLAG_OVF:    ovf <= 1'b1;
      OP_PUSH_SAMPLE: begin
        sel <= to_upper;
        val <= sample_r;
        pos <= AW'(to_upper ? upper_count : lower_count);
      end
      OP_UP_MOVE:     pos <= par;
      OP_POP_START: begin
        sel    <= !lower_big;
        popped <= lower_big ? lower_top : upper_top;
      end
      OP_POP_LAST: begin
        val <= rdata;
        n   <= cnt_sel;
        pos <= '0;
      end
      OP_DN_READ_R:   cl <= rdata;
      OP_DN_MOVE:     pos <= br ? ridx[AW-1:0] : lidx[AW-1:0];
      OP_REPUSH: begin
        sel <= !sel;
        val <= popped;
        pos <= AW'(cnt_oth);
      end
      OP_RESULT: begin
        held_count <= HELD_W'(held);
        overflow   <= ovf;
        if (lower_count == upper_count)     median_doubled <= lo_ext + up_ext;
        else if (lower_count > upper_count) median_doubled <= {lower_top, 1'b0};
        else                                median_doubled <= {upper_top, 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_count <= '0;
      upper_count <= '0;
    end else begin
      priority case (op)
        OP_PUSH_SAMPLE: begin
          if (to_upper) upper_count <= upper_count + CNTW'(1);
          else          lower_count <= lower_count + CNTW'(1);
        end
        OP_POP_START: begin
          if (lower_big) lower_count <= lower_count - CNTW'(1);
          else           upper_count <= upper_count - CNTW'(1);
        end
        OP_REPUSH: begin
          if (sel) lower_count <= lower_count + CNTW'(1);
          else     upper_count <= upper_count + CNTW'(1);
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/rmth_controller.sv
// Sequencer for insert, rebalance and result; drives datapath commands.
// Depends on rmth_pkg.
`default_nettype none
module rmth_controller (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire rmth_pkg::status_t status,
  output rmth_pkg::op_t          op
);
  import rmth_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_UP_C, S_UP_M, S_BAL, S_POP, S_DN_L, S_DN_R, S_DN_C,
    S_REPUSH, S_RESULT
  } state_t;

  state_t state, state_next;
  logic   rebal;   // second push (rebalance) under way
  state_t after_push;

  assign in_ready   = state == S_IDLE;
  assign after_push = rebal ? S_RESULT : S_BAL;

  always_comb begin
    op         = OP_NONE;
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) begin
        op         = OP_LOAD;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        op         = status.full ? OP_FLAG_OVF : OP_PUSH_SAMPLE;
        state_next = status.full ? S_RESULT : S_UP_C;
      end
      S_UP_C: begin
        op         = status.pos_zero ? OP_WRITE_VAL : OP_UP_READ;
        state_next = status.pos_zero ? after_push : S_UP_M;
      end
      S_UP_M: begin
        op         = status.up_above ? OP_UP_MOVE : OP_WRITE_VAL;
        state_next = status.up_above ? S_UP_C : after_push;
      end
      S_BAL: begin
        op         = status.unbalanced ? OP_POP_START : OP_NONE;
        state_next = status.unbalanced ? S_POP : S_RESULT;
      end
      S_POP: begin
        op         = OP_POP_LAST;
        state_next = status.n_zero ? S_REPUSH : S_DN_L;
      end
      S_DN_L: begin
        op         = status.l_in ? OP_DN_READ_L : OP_WRITE_VAL;
        state_next = status.l_in ? S_DN_R : S_REPUSH;
      end
      S_DN_R: begin
        op         = OP_DN_READ_R;
        state_next = S_DN_C;
      end
      S_DN_C: begin
        op         = status.dn_move ? OP_DN_MOVE : OP_WRITE_VAL;
        state_next = status.dn_move ? S_DN_L : S_REPUSH;
      end
      S_REPUSH: begin
        op         = OP_REPUSH;
        state_next = S_UP_C;
      end
      S_RESULT: if (!out_valid || out_ready) begin
        op         = OP_RESULT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rebal     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == OP_PUSH_SAMPLE) rebal <= 1'b0;
      if (op == OP_REPUSH)      rebal <= 1'b1;
      if (op == OP_RESULT)            out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> hdl/rmth_checker.sv
// Port-level checks on the running median top, and the bind that attaches them.
// Depends on rmth_pkg and running_median_two_heaps_top.
`default_nettype none
module rmth_checker #(
  parameter int unsigned CAPACITY = rmth_pkg::CAPACITY_DEF
) (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 in_valid,
  input wire logic                                 in_ready,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic signed [rmth_pkg::MED_W-1:0]    median_doubled,
  input wire logic        [rmth_pkg::HELD_W-1:0]   held_count,
  input wire logic                                 overflow
);
  import rmth_pkg::*;

  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(median_doubled) && $stable(held_count)
                                && $stable(overflow))
    else $error("result changed while stalled");

  // A dropped sample only happens with a full store.
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> held_count == HELD_W'(CAPACITY))
    else $error("overflow without full store");

  // One request at a time: busy right after accepting.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second sample taken while busy");

  // No result straight out of reset.
  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind running_median_two_heaps_top rmth_checker #(.CAPACITY(CAPACITY)) u_rmth_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (sample_in.valid),
  .in_ready       (sample_in.ready),
  .out_valid      (result_out.valid),
  .out_ready      (result_out.ready),
  .median_doubled (result_out.median_doubled),
  .held_count     (result_out.held_count),
  .overflow       (result_out.overflow)
);
`default_nettype wire
